// ===== hw/rtl/prpag_pkg.sv =====
// Package: shared types and constants for the permute row page address generator.
package prpag_pkg;
    localparam int CfgIdxBits = 3;
    localparam int CfgDataBits = 64;

    localparam logic [CfgIdxBits-1:0] REG_AXIS_COUNT  = 3'd0;
    localparam logic [CfgIdxBits-1:0] REG_AXIS_SIZES  = 3'd1;
    localparam logic [CfgIdxBits-1:0] REG_SOURCE_MAP  = 3'd2;
    localparam logic [CfgIdxBits-1:0] REG_STRIDES_LO  = 3'd3;
    localparam logic [CfgIdxBits-1:0] REG_STRIDES_HI  = 3'd4;
    localparam logic [CfgIdxBits-1:0] REG_BASE_ROW    = 3'd5;
    localparam logic [CfgIdxBits-1:0] REG_ROW_COUNT   = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_DIV,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic init;       // clear positions, invert map
        logic div_start;  // begin divide for current axis
        logic sum_step;   // accumulate one axis into page
        logic advance;    // odometer step
        logic load_out;   // capture result
        logic restart;    // zero axis counter for the sum
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic div_last;   // no more axes to split
        logic sum_last;   // no more axes to sum
    } status_t;
endpackage

// ===== hw/rtl/permute_row_page_address_generator_unit.sv =====
// Top level: permute row page address generator, config registers and unit wiring.
// Advance item (restart 0): result in the output register the next cycle.
// Restart item: for each of the k axes in use a 32-bit serial divide (one quotient
// bit a cycle), then one multiply-add per axis, then the result is loaded into the
// output register. Throughput: one advance a cycle while in_stall is low.
// Reset (rst_n, async low): axis_count 1, rest zero; divider/output data not reset.
module permute_row_page_address_generator_unit #(
    parameter int MAX_AXES = 4,
    parameter int SIZE_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_write,
    input  logic [prpag_pkg::CfgIdxBits-1:0] cfg_index,
    input  logic [prpag_pkg::CfgDataBits-1:0] cfg_data,
    input  logic in_valid,
    output logic in_stall,
    input  logic restart,
    output logic out_valid,
    input  logic out_stall,
    output logic [31:0] row_page,
    output logic last_row,
    output logic past_end
);
    import prpag_pkg::*;

    // configuration registers
    logic [2:0]  axis_count_reg;
    logic [63:0] axis_sizes_reg;
    logic [7:0]  source_map_reg;
    logic [63:0] strides_lo_reg;
    logic [63:0] strides_hi_reg;
    logic [31:0] base_row_reg;
    logic [31:0] row_count_reg;

    cmd_t cmd;
    status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_count_reg <= 3'd1;
            axis_sizes_reg <= '0;
            source_map_reg <= '0;
            strides_lo_reg <= '0;
            strides_hi_reg <= '0;
            base_row_reg <= '0;
            row_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                REG_AXIS_COUNT: axis_count_reg <= cfg_data[2:0];
                REG_AXIS_SIZES: axis_sizes_reg <= cfg_data;
                REG_SOURCE_MAP: source_map_reg <= cfg_data[7:0];
                REG_STRIDES_LO: strides_lo_reg <= cfg_data;
                REG_STRIDES_HI: strides_hi_reg <= cfg_data;
                REG_BASE_ROW:   base_row_reg <= cfg_data[31:0];
                REG_ROW_COUNT:  row_count_reg <= cfg_data[31:0];
                default: ;
            endcase
        end
    end

    prpag_controller u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .restart(restart),
        .out_valid(out_valid), .out_stall(out_stall),
        .status(status), .cmd(cmd)
    );

    prpag_datapath #(.MAX_AXES(MAX_AXES), .SIZE_BITS(SIZE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n),
        .axis_count(axis_count_reg), .axis_sizes(axis_sizes_reg),
        .axis_source_map(source_map_reg),
        .strides_low_pair(strides_lo_reg), .strides_high_pair(strides_hi_reg),
        .base_row(base_row_reg), .row_count(row_count_reg),
        .cmd(cmd), .status(status),
        .row_page(row_page), .last_row(last_row), .past_end(past_end)
    );
endmodule

// ===== hw/rtl/prpag_datapath.sv =====
// Datapath: axis state, serial divider, page accumulator and output register.
module prpag_datapath #(
    parameter int MAX_AXES = 4,
    parameter int SIZE_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic [2:0] axis_count,
    input  logic [63:0] axis_sizes,
    input  logic [7:0] axis_source_map,
    input  logic [63:0] strides_low_pair,
    input  logic [63:0] strides_high_pair,
    input  logic [31:0] base_row,
    input  logic [31:0] row_count,
    input  prpag_pkg::cmd_t cmd,
    output prpag_pkg::status_t status,
    output logic [31:0] row_page,
    output logic last_row,
    output logic past_end
);
    import prpag_pkg::*;

    localparam int AW = (MAX_AXES > 1) ? $clog2(MAX_AXES) : 1;
    localparam int KW = $clog2(MAX_AXES + 1);

    logic [SIZE_BITS-1:0] pos_reg [MAX_AXES];
    logic [SIZE_BITS-1:0] pos_next [MAX_AXES];
    logic [31:0] stride_reg [MAX_AXES];
    logic [31:0] stride_next [MAX_AXES];
    logic [31:0] wrap_reg [MAX_AXES];
    logic [31:0] wrap_next [MAX_AXES];
    logic [31:0] page_reg, page_next;
    logic [31:0] rows_reg, rows_next;
    logic [KW-1:0] k_used;
    logic [KW-1:0] step_reg, step_next;      // axes processed so far
    logic [31:0] rem_reg, rem_next;          // dividend / quotient
    logic [SIZE_BITS-1:0] part_reg, part_next; // partial remainder
    logic [5:0] bit_reg, bit_next;
    logic busy_reg, busy_next;
    logic [31:0] page_out_reg, page_out_next;
    logic last_reg, last_next, past_reg, past_next;

    function automatic logic [SIZE_BITS-1:0] size_of(input logic [63:0] sz,
                                                     input logic [AW-1:0] d);
        logic [SIZE_BITS-1:0] s;
        s = sz[16*d +: SIZE_BITS];
        return (s == '0) ? SIZE_BITS'(1) : s;
    endfunction

    always_comb
    begin
        if (axis_count > 3'(MAX_AXES))
            k_used = KW'(MAX_AXES);
        else
            k_used = KW'(axis_count);
    end

    logic [AW-1:0] div_dim, sum_dim;
    logic [SIZE_BITS-1:0] div_size;
    logic [SIZE_BITS:0] trial;
    logic [KW:0] dim_wide;
    logic [31:0] prod;
    logic carry;
    logic [SIZE_BITS:0] inc;

    always_comb
    begin
        dim_wide = (KW+1)'(k_used) - (KW+1)'(step_reg) - 1'b1;
        div_dim = AW'(dim_wide);
        sum_dim = AW'(step_reg);
        div_size = size_of(axis_sizes, div_dim);
        trial = {part_reg, rem_reg[31]};
        prod = 32'(pos_reg[sum_dim]) * stride_reg[sum_dim];
        for (int d = 0; d < MAX_AXES; d++)
        begin
            pos_next[d] = pos_reg[d];
            stride_next[d] = stride_reg[d];
            wrap_next[d] = wrap_reg[d];
        end
        page_next = page_reg;
        rows_next = rows_reg;
        step_next = step_reg;
        rem_next = rem_reg;
        part_next = part_reg;
        bit_next = bit_reg;
        busy_next = busy_reg;
        page_out_next = page_out_reg;
        last_next = last_reg;
        past_next = past_reg;
        carry = 1'b1;
        inc = '0;

        if (cmd.init)
        begin
            for (int d = 0; d < MAX_AXES; d++)
            begin
                pos_next[d] = '0;
                stride_next[d] = '0;
                wrap_next[d] = '0;
            end
            for (int i = 0; i < MAX_AXES; i++)
            begin
                if (KW'(i) < k_used && int'(axis_source_map[2*i +: 2]) < MAX_AXES)
                    stride_next[AW'(axis_source_map[2*i +: 2])] =
                        (i >= 2) ? strides_high_pair[32*(i & 1) +: 32]
                                 : strides_low_pair[32*(i & 1) +: 32];
            end
            page_next = '0;
            rows_next = '0;
            step_next = '0;
            rem_next = base_row;
            busy_next = 1'b0;
        end
        if (cmd.div_start)
        begin
            busy_next = 1'b1;
            bit_next = 6'd32;
            part_next = '0;
        end
        else if (busy_reg)
        begin
            // restoring divide, one quotient bit per cycle
            if (trial >= {1'b0, div_size})
            begin
                part_next = SIZE_BITS'(trial - {1'b0, div_size});
                rem_next = {rem_reg[30:0], 1'b1};
            end
            else
            begin
                part_next = SIZE_BITS'(trial);
                rem_next = {rem_reg[30:0], 1'b0};
            end
            bit_next = bit_reg - 1'b1;
            if (bit_reg == 6'd1)
            begin
                busy_next = 1'b0;
                pos_next[div_dim] = part_next;
                step_next = step_reg + 1'b1;
            end
        end
        if (cmd.sum_step)
        begin
            page_next = page_reg + prod;
            wrap_next[sum_dim] = 32'(size_of(axis_sizes, sum_dim) - 1'b1)
                                 * stride_reg[sum_dim];
            step_next = step_reg + 1'b1;
        end
        // split done: axis counter starts over for the sum
        if (cmd.restart)
            step_next = '0;
        if (cmd.advance)
        begin
            for (int i = 0; i < MAX_AXES; i++)
            begin
                if (KW'(i) < k_used && carry)
                begin
                    inc = {1'b0, pos_reg[AW'(int'(k_used) - 1 - i)]} + 1'b1;
                    if (inc < {1'b0, size_of(axis_sizes, AW'(int'(k_used) - 1 - i))})
                    begin
                        pos_next[AW'(int'(k_used) - 1 - i)] = SIZE_BITS'(inc);
                        page_next = page_next + stride_reg[AW'(int'(k_used) - 1 - i)];
                        carry = 1'b0;
                    end
                    else
                    begin
                        pos_next[AW'(int'(k_used) - 1 - i)] = '0;
                        page_next = page_next - wrap_reg[AW'(int'(k_used) - 1 - i)];
                    end
                end
            end
            if (rows_reg != 32'hFFFF_FFFF)
                rows_next = rows_reg + 1'b1;
        end
        if (cmd.load_out)
        begin
            page_out_next = page_next;
            last_next = (row_count != 0) && (rows_next == row_count - 1'b1);
            past_next = rows_next >= row_count;
        end
    end

    assign status.div_done = busy_reg && bit_reg == 6'd1;
    assign status.div_last = (step_reg >= k_used);
    assign status.sum_last = (step_reg >= k_used);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int d = 0; d < MAX_AXES; d++)
            begin
                pos_reg[d] <= '0;
                stride_reg[d] <= '0;
                wrap_reg[d] <= '0;
            end
            page_reg <= '0;
            rows_reg <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
            bit_reg <= '0;
        end
        else
        begin
            for (int d = 0; d < MAX_AXES; d++)
            begin
                pos_reg[d] <= pos_next[d];
                stride_reg[d] <= stride_next[d];
                wrap_reg[d] <= wrap_next[d];
            end
            page_reg <= page_next;
            rows_reg <= rows_next;
            step_reg <= step_next;
            busy_reg <= busy_next;
            bit_reg <= bit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        part_reg <= part_next;
        page_out_reg <= page_out_next;
        last_reg <= last_next;
        past_reg <= past_next;
    end

    assign row_page = page_out_reg;
    assign last_row = last_reg;
    assign past_end = past_reg;

`ifndef SYNTHESIS
    a_div_bits: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> bit_reg != 6'd0) else $error("divider ran past last bit");
    a_adv_rows: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |=> rows_reg != 32'd0) else $error("row count did not move");
    a_init_page: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.init |=> page_reg == 32'd0) else $error("page not cleared on restart");
`endif
endmodule

// ===== hw/rtl/prpag_controller.sv =====
// Controller: sequences restart split and sum, odometer steps and the output handshake.
module prpag_controller (
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_stall,
    input  logic restart,
    output logic out_valid,
    input  logic out_stall,
    input  prpag_pkg::status_t status,
    output prpag_pkg::cmd_t cmd
);
    import prpag_pkg::*;

    state_t state_reg, state_next;
    logic full_reg, full_next;
    logic accept;

    assign accept = in_valid && !in_stall;
    assign out_valid = full_reg;

    always_comb
    begin
        state_next = state_reg;
        full_next = full_reg && out_stall;
        cmd = '0;
        in_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_stall = full_reg && out_stall;
                if (accept)
                begin
                    if (restart)
                    begin
                        cmd.init = 1'b1;
                        state_next = ST_INIT;
                    end
                    else
                    begin
                        cmd.advance = 1'b1;
                        cmd.load_out = 1'b1;
                        full_next = 1'b1;
                    end
                end
            end
            ST_INIT:
            begin
                if (status.div_last)
                begin
                    cmd.restart = 1'b1; // zero axis counter for the sum
                    state_next = ST_SUM;
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (status.div_done)
                    state_next = ST_INIT;
            end
            ST_SUM:
            begin
                if (status.sum_last)
                    state_next = ST_OUT;
                else
                    cmd.sum_step = 1'b1;
            end
            ST_OUT:
            begin
                if (!(full_reg && out_stall))
                begin
                    cmd.load_out = 1'b1;
                    full_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            full_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            full_reg <= full_next;
        end
    end

`ifndef SYNTHESIS
    a_stall_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> in_stall) else $error("item taken while busy");
    a_restart_seq: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && restart) |=> state_reg == ST_INIT) else $error("restart not started");
    a_load_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> full_reg) else $error("result lost");
`endif
endmodule
